// File: design/assert_macros.svh
// Assertion macros for the follow controller RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PFC_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, held off during reset.
`define PFC_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// File: design/pfc_pkg.sv
// Shared types, widths and constants of the pneumatic follow controller.
// No dependencies; every other RTL file but assert_macros.svh imports it.
`default_nettype none

package pfc_pkg;

	localparam int PFC_PAIR_COUNT    = 3;
	localparam int PFC_FRACTION_BITS = 8;

	localparam int SAMPLE_W   = 10;
	localparam int PAIR_W     = 2;
	localparam int LEVEL_W    = 8;
	localparam int ERR_W      = 9;
	localparam int COEF_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DIV_STEPS  = LEVEL_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int DUTY_SHIFT = 4;

	localparam logic             ENABLE_RST     = 1'b0;
	localparam logic [COEF_W-1:0] KEEP_RST      = 8'd230;
	localparam logic [COEF_W-1:0] GAIN_RST      = 8'd40;
	localparam logic [COEF_W-1:0] RESOLUTION_RST = 8'd100;
	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 10'd412;
	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 10'd612;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_KEEP       = 3'd1,
		REG_GAIN       = 3'd2,
		REG_RESOLUTION = 3'd3,
		REG_RANGE_LOW  = 3'd4,
		REG_RANGE_HIGH = 3'd5
	} pfc_reg_t;

	typedef enum logic [1:0] {
		MODE_EXHAUST = 2'd0,
		MODE_SUPPLY  = 2'd1,
		MODE_VACUUM  = 2'd2,
		MODE_CLOSE   = 2'd3
	} pfc_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILT_MUL,
		S_FILT_SUM,
		S_MAP_DIFF,
		S_MAP_MUL,
		S_MAP_SAT,
		S_DIV,
		S_COMMIT,
		S_DECIDE
	} pfc_state_t;

	typedef struct packed {
		logic              enable;
		logic [COEF_W-1:0] filter_keep;
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] resolution;
	} pfc_cfg_t;

	typedef struct packed {
		logic                load_min;
		logic                load_max;
		logic [SAMPLE_W-1:0] value;
	} pfc_reload_t;

	typedef struct packed {
		logic capture;
		logic filt_mul;
		logic filt_sum;
		logic map_diff;
		logic map_mul;
		logic map_sat;
		logic div_step;
		logic commit;
		logic load_out;
		logic chan_target;
	} pfc_cmd_t;

	typedef struct packed {
		logic pair_bad;
	} pfc_status_t;

endpackage

`default_nettype wire

// File: design/pfc_ifs.sv
// Valid/ready channel interfaces: sample frames, results and register writes.
// Depends on pfc_pkg for field widths.
`default_nettype none

interface pfc_frame_if;
	import pfc_pkg::*;
	logic                valid;
	logic                ready;
	logic [PAIR_W-1:0]   pair_index;
	logic [SAMPLE_W-1:0] target_sample;
	logic [SAMPLE_W-1:0] follower_sample;
	modport source (output valid, pair_index, target_sample, follower_sample, input ready);
	modport sink (input valid, pair_index, target_sample, follower_sample, output ready);
endinterface

interface pfc_result_if;
	import pfc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              valve_mode;
	logic [LEVEL_W-1:0]      pump_duty;
	logic [LEVEL_W-1:0]      target_level;
	logic [LEVEL_W-1:0]      follower_level;
	logic signed [ERR_W-1:0] level_error;
	modport source (output valid, valve_mode, pump_duty, target_level, follower_level,
		level_error, input ready);
	modport sink (input valid, valve_mode, pump_duty, target_level, follower_level,
		level_error, output ready);
endinterface

interface pfc_cfg_if;
	import pfc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/pfc_regs.sv
// Configuration registers and range reload strobes.
// Depends on pfc_pkg and the pfc_cfg_if interface.
`default_nettype none

module pfc_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	pfc_cfg_if.sink            cfg_port,
	output pfc_pkg::pfc_cfg_t    cfg,
	output pfc_pkg::pfc_reload_t reload
);
	import pfc_pkg::*;

	pfc_cfg_t cfg_q;
	logic     wr;

	assign cfg_port.ready = 1'b1;
	assign wr = cfg_port.valid && cfg_port.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= ENABLE_RST;
			cfg_q.filter_keep <= KEEP_RST;
			cfg_q.gain        <= GAIN_RST;
			cfg_q.resolution  <= RESOLUTION_RST;
		end else if (wr) begin
			unique case (cfg_port.index)
				REG_ENABLE:     cfg_q.enable      <= cfg_port.data[0];
				REG_KEEP:       cfg_q.filter_keep <= cfg_port.data[COEF_W-1:0];
				REG_GAIN:       cfg_q.gain        <= cfg_port.data[COEF_W-1:0];
				REG_RESOLUTION: cfg_q.resolution  <= cfg_port.data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// Range start writes reload every channel in the datapath at the same edge.
	always_comb begin
		reload.load_min = wr && (cfg_port.index == REG_RANGE_LOW);
		reload.load_max = wr && (cfg_port.index == REG_RANGE_HIGH);
		reload.value    = cfg_port.data[SAMPLE_W-1:0];
	end

endmodule

`default_nettype wire

// File: design/pfc_ctrl.sv
// Sequencer for the follow controller: walks both channels of a frame through
// filter, mapping and divider steps. Depends on pfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pfc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_ready,
	input  pfc_pkg::pfc_status_t st,
	output logic               in_ready,
	output logic               out_valid,
	output pfc_pkg::pfc_cmd_t  cmd
);
	import pfc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	pfc_state_t           state_q, state_d;
	logic                 chan_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 div_done;
	logic                 commit_first;

	assign out_free     = !out_valid_q || out_ready;
	assign div_done     = (state_q == S_DIV) && (div_cnt_q == DIV_LAST);
	assign commit_first = (state_q == S_COMMIT) && !chan_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_FILT_MUL;
			S_FILT_MUL: state_d = st.pair_bad ? S_DECIDE : S_FILT_SUM;
			S_FILT_SUM: state_d = S_MAP_DIFF;
			S_MAP_DIFF: state_d = S_MAP_MUL;
			S_MAP_MUL:  state_d = S_MAP_SAT;
			S_MAP_SAT:  state_d = S_DIV;
			S_DIV:      if (div_done) state_d = S_COMMIT;
			S_COMMIT:   state_d = chan_q ? S_DECIDE : S_FILT_MUL;
			S_DECIDE:   if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.chan_target = chan_q;
		in_ready        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_FILT_MUL: cmd.filt_mul = 1'b1;
			S_FILT_SUM: cmd.filt_sum = 1'b1;
			S_MAP_DIFF: cmd.map_diff = 1'b1;
			S_MAP_MUL:  cmd.map_mul  = 1'b1;
			S_MAP_SAT:  cmd.map_sat  = 1'b1;
			S_DIV:      cmd.div_step = 1'b1;
			S_COMMIT:   cmd.commit   = 1'b1;
			S_DECIDE:   cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chan_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				chan_q <= 1'b0;
			end else if (cmd.commit) begin
				chan_q <= 1'b1;
			end
			if (cmd.map_sat) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`PFC_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`PFC_ASSERT_NXT(a_div_len, clk, arst_n, div_done, state_q == S_COMMIT)
	`PFC_ASSERT_NXT(a_second_chan, clk, arst_n, commit_first, state_q == S_FILT_MUL && chan_q)

endmodule

`default_nettype wire

// File: design/pfc_datapath.sv
// Datapath: per-channel filter, range mapping with a shared restoring divider,
// range state, valve decision and the result register. Depends on pfc_pkg.
`default_nettype none

module pfc_datapath #(
	parameter int PAIR_COUNT    = pfc_pkg::PFC_PAIR_COUNT,
	parameter int FRACTION_BITS = pfc_pkg::PFC_FRACTION_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  pfc_pkg::pfc_cmd_t                  cmd,
	input  pfc_pkg::pfc_cfg_t                  cfg,
	input  pfc_pkg::pfc_reload_t               reload,
	input  wire logic [pfc_pkg::PAIR_W-1:0]    pair_index,
	input  wire logic [pfc_pkg::SAMPLE_W-1:0]  target_sample,
	input  wire logic [pfc_pkg::SAMPLE_W-1:0]  follower_sample,
	output pfc_pkg::pfc_status_t               st,
	output pfc_pkg::pfc_mode_t                 valve_mode,
	output logic [pfc_pkg::LEVEL_W-1:0]        pump_duty,
	output logic [pfc_pkg::LEVEL_W-1:0]        target_level,
	output logic [pfc_pkg::LEVEL_W-1:0]        follower_level,
	output logic signed [pfc_pkg::ERR_W-1:0]   level_error
);
	import pfc_pkg::*;

	localparam int CHANNELS = 2 * PAIR_COUNT;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int PI_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
	localparam int FW       = SAMPLE_W + FRACTION_BITS;
	localparam int KW       = COEF_W + 1;
	localparam int NW       = FW + COEF_W;
	localparam int DW       = COEF_W + LEVEL_W;

	// captured frame
	logic [PAIR_W-1:0]   pair_s1;
	logic [SAMPLE_W-1:0] tsamp_s1, fsamp_s1;
	logic                bad_s1;

	// channel state
	logic [FW-1:0]         filt_q [CHANNELS];
	logic [FW-1:0]         min_q  [CHANNELS];
	logic [FW-1:0]         max_q  [CHANNELS];
	logic [PAIR_COUNT-1:0] pol_q;

	// per-channel work registers
	logic [FW+COEF_W-1:0] pk_q;
	logic [FW+KW-1:0]     pn_q;
	logic [FW-1:0]        fnew_q;
	logic [FW-1:0]        adiff_q, aden_q;
	logic                 den_zero_q, neg_q;
	logic [NW-1:0]        anum_q, rem_q, dv_q;
	logic                 sat_q;
	logic [LEVEL_W-1:0]   quo_q;
	logic [LEVEL_W-1:0]   tl_q, fl_q;

	// result register
	pfc_mode_t               mode_q;
	logic [LEVEL_W-1:0]      duty_q, tlo_q, flo_q;
	logic signed [ERR_W-1:0] err_q;

	logic [CH_W-1:0]         ch;
	logic [SAMPLE_W-1:0]     samp;
	logic [FW-1:0]           x_fix;
	logic [KW-1:0]           keep_inv;
	logic [FW+KW-1:0]        fsum;
	logic [FW:0]             diff, den;
	logic [FW:0]             diff_abs, den_abs;
	logic [LEVEL_W-1:0]      level;
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        err_abs;
	logic [LEVEL_W-1:0]      mag;
	logic [DW-1:0]           dprod;
	logic [LEVEL_W-1:0]      duty;
	logic [PI_W-1:0]         pidx;

	assign ch = cmd.chan_target ? (CH_W'(pair_s1) + CH_W'(PAIR_COUNT)) : CH_W'(pair_s1);
	assign pidx     = PI_W'(pair_s1);
	assign samp     = cmd.chan_target ? tsamp_s1 : fsamp_s1;
	assign x_fix    = FW'(samp) << FRACTION_BITS;
	assign keep_inv = KW'(1 << COEF_W) - KW'(cfg.filter_keep);
	assign fsum     = (FW + KW)'(pk_q) + pn_q;

	assign diff     = {1'b0, max_q[ch]} - {1'b0, fnew_q};
	assign den      = {1'b0, max_q[ch]} - {1'b0, min_q[ch]};
	assign diff_abs = diff[FW] ? -diff : diff;
	assign den_abs  = den[FW] ? -den : den;

	always_comb begin
		if (den_zero_q) begin
			level = cfg.resolution;
		end else if (neg_q) begin
			level = '0;
		end else if (sat_q) begin
			level = '1;
		end else begin
			level = quo_q;
		end
	end

	assign err     = $signed({1'b0, tl_q}) - $signed({1'b0, fl_q});
	assign err_abs = err[ERR_W-1] ? -err : err;
	assign mag     = err_abs[LEVEL_W-1:0];
	assign dprod   = DW'(cfg.gain) * DW'(mag);
	assign duty    = (|dprod[DW-1:LEVEL_W+DUTY_SHIFT]) ? '1
		: dprod[LEVEL_W+DUTY_SHIFT-1:DUTY_SHIFT];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pair_s1  <= pair_index;
			tsamp_s1 <= target_sample;
			fsamp_s1 <= follower_sample;
			bad_s1   <= int'(pair_index) >= PAIR_COUNT;
		end
		if (cmd.filt_mul) begin
			pk_q <= NW'(cfg.filter_keep) * NW'(filt_q[ch]);
			pn_q <= (FW + KW)'(keep_inv) * (FW + KW)'(x_fix);
		end
		if (cmd.filt_sum) begin
			fnew_q <= fsum[FW+COEF_W-1:COEF_W];
		end
		if (cmd.map_diff) begin
			adiff_q    <= diff_abs[FW-1:0];
			aden_q     <= den_abs[FW-1:0];
			neg_q      <= diff[FW] ^ den[FW];
			den_zero_q <= (den == '0);
		end
		if (cmd.map_mul) begin
			anum_q <= NW'(cfg.resolution) * NW'(adiff_q);
		end
		// restoring division, one quotient bit a step
		if (cmd.map_sat) begin
			sat_q <= anum_q >= (NW'(aden_q) << LEVEL_W);
			rem_q <= anum_q;
			dv_q  <= NW'(aden_q) << (LEVEL_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.commit) begin
			if (cmd.chan_target) begin
				tl_q <= level;
			end else begin
				fl_q <= level;
			end
		end
		if (cmd.load_out) begin
			if (bad_s1) begin
				mode_q <= MODE_EXHAUST;
				duty_q <= '0;
				tlo_q  <= '0;
				flo_q  <= '0;
				err_q  <= '0;
			end else begin
				tlo_q <= tl_q;
				flo_q <= fl_q;
				err_q <= err;
				if (!cfg.enable) begin
					mode_q <= MODE_EXHAUST;
					duty_q <= '0;
				end else if (mag == '0) begin
					mode_q <= MODE_CLOSE;
					duty_q <= '0;
				end else begin
					mode_q <= err[ERR_W-1] ? MODE_VACUUM : MODE_SUPPLY;
					duty_q <= duty;
				end
			end
		end
	end

	// Channel state: reset and range reloads touch every entry, a commit one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				filt_q[c] <= '0;
				min_q[c]  <= FW'(RANGE_LOW_RST) << FRACTION_BITS;
				max_q[c]  <= FW'(RANGE_HIGH_RST) << FRACTION_BITS;
			end
			pol_q <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (reload.load_min) begin
					min_q[c] <= FW'(reload.value) << FRACTION_BITS;
				end
				if (reload.load_max) begin
					max_q[c] <= FW'(reload.value) << FRACTION_BITS;
				end
			end
			if (cmd.commit) begin
				filt_q[ch] <= fnew_q;
				if (fnew_q > max_q[ch]) begin
					max_q[ch] <= fnew_q;
				end
				if (fnew_q < min_q[ch]) begin
					min_q[ch] <= fnew_q;
				end
			end
			// hold polarity when disabled, for an unused pair or when levels agree
			if (cmd.load_out && !bad_s1 && cfg.enable && mag != '0) begin
				pol_q[pidx] <= !err[ERR_W-1];
			end
		end
	end

	assign st.pair_bad    = bad_s1;
	assign valve_mode     = mode_q;
	assign pump_duty      = duty_q;
	assign target_level   = tlo_q;
	assign follower_level = flo_q;
	assign level_error    = err_q;

endmodule

`default_nettype wire

// File: design/pneumatic_follow_controller_top.sv
// Pneumatic follow controller: frames of target/follower samples in, valve
// mode, pump duty and mapped levels out. Use:
//   frame  - sink channel; one transfer per pair of raw 10-bit samples.
//   result - source channel; exactly one transfer per accepted frame, in order.
//   cfg    - register write channel, always ready; write only while idle.
// A new frame is taken only while the sequencer is idle, once the previous
// frame has been computed. Each of the two channels passes in order through
// the low-pass filter multiply and sum, the mapping difference, multiply and
// range check, the shared restoring divider (one quotient bit a cycle), and a
// commit of the level that widens the range. A final step forms error, duty
// and mode.
// A frame with an unused pair index skips straight to an all-zero result.
// Reset: registers take their defaults, filtered values clear, every range
// loads from the start values and all held polarities read vacuum; no
// clearing pass, the block is ready at once.
// Stall: the result waits in the output register; the next frame is still
// taken and computed, then held until the waiting result has been taken.
// Depends on pfc_pkg, pfc_ifs, pfc_regs, pfc_ctrl and pfc_datapath.
`default_nettype none

module pneumatic_follow_controller_top #(
	parameter int PAIR_COUNT    = pfc_pkg::PFC_PAIR_COUNT,
	parameter int FRACTION_BITS = pfc_pkg::PFC_FRACTION_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pfc_frame_if.sink    frame,
	pfc_result_if.source result,
	pfc_cfg_if.sink      cfg
);
	import pfc_pkg::*;

	pfc_cfg_t    cfg_regs;
	pfc_reload_t reload;
	pfc_cmd_t    cmd;
	pfc_status_t st;
	pfc_mode_t   mode;

	// Register file: static settings plus range reload strobes.
	pfc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_port (cfg),
		.cfg      (cfg_regs),
		.reload   (reload)
	);

	// Sequencer: owns the frame and result handshakes and steps the datapath.
	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame.valid),
		.out_ready (result.ready),
		.st        (st),
		.in_ready  (frame.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	// Arithmetic, channel state and the result register.
	pfc_datapath #(
		.PAIR_COUNT    (PAIR_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_regs),
		.reload          (reload),
		.pair_index      (frame.pair_index),
		.target_sample   (frame.target_sample),
		.follower_sample (frame.follower_sample),
		.st              (st),
		.valve_mode      (mode),
		.pump_duty       (result.pump_duty),
		.target_level    (result.target_level),
		.follower_level  (result.follower_level),
		.level_error     (result.level_error)
	);

	assign result.valve_mode = mode;

endmodule

`default_nettype wire

// File: verif/pneumatic_follow_controller_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pneumatic_follow_controller_top: random and directed sample frames,
// register writes between batches, every result checked against an in-bench level predictor.
// Depends on pfc_pkg, pfc_ifs and the controller RTL.

module pneumatic_follow_controller_top_tb;
	import pfc_pkg::*;

	localparam int CHANNELS     = 2 * PFC_PAIR_COUNT;
	localparam int FIX_W        = SAMPLE_W + PFC_FRACTION_BITS;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int PAIR_TOP     = (1 << PAIR_W) - 1;
	localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
	localparam int WEIGHT_ONE   = 256;
	localparam int WEIGHT_SHIFT = 8;
	localparam int GAP_MAX      = 9;
	localparam int TAIL_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LIMIT = 200;
	// unused register index: a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic [PAIR_W-1:0]   pair;
		logic [SAMPLE_W-1:0] target;
		logic [SAMPLE_W-1:0] follower;
		int                  gap;
	} sample_frame_t;

	typedef struct {
		pfc_mode_t               mode;
		logic [LEVEL_W-1:0]      duty;
		logic [LEVEL_W-1:0]      tgt_level;
		logic [LEVEL_W-1:0]      fol_level;
		logic signed [ERR_W-1:0] error;
	} valve_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	pfc_frame_if  frame_ch ();
	pfc_result_if result_ch ();
	pfc_cfg_if    cfg_ch ();

	pneumatic_follow_controller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the register file
	logic                  run_enable;
	logic [COEF_W-1:0]     keep_weight;
	logic [COEF_W-1:0]     gain_q44;
	logic [COEF_W-1:0]     full_scale;
	logic [SAMPLE_W-1:0]   low_start;
	logic [SAMPLE_W-1:0]   high_start;

	// Predictor copy of the per-channel state; follower channels first, then targets
	logic [FIX_W-1:0] smooth_val [CHANNELS];
	logic [FIX_W-1:0] span_lo    [CHANNELS];
	logic [FIX_W-1:0] span_hi    [CHANNELS];
	bit               push_sign  [PFC_PAIR_COUNT];

	sample_frame_t  frame_backlog[$];
	valve_outcome_t valve_forecast[$];
	sample_frame_t  frame_in_flight;

	bit steady;                 // no gaps and no stalls while set
	int gap_count;
	int stall_left;
	int frames_issued;
	int frames_accepted;
	int results_seen;
	int regs_written;
	int mismatches;
	int cycle_count;
	int mode_tally [4];
	int chase_target   [PAIR_TOP+1];
	int chase_follower [PAIR_TOP+1];

	// Filter one channel, map it against its tracked range, then widen the range.
	function automatic int track_channel(input int ch, input logic [SAMPLE_W-1:0] sample);
		longint acc;
		longint lvl;
		logic [FIX_W-1:0] f;
		acc = longint'(keep_weight) * longint'(smooth_val[ch])
			+ longint'(WEIGHT_ONE - int'(keep_weight)) * (longint'(sample) << PFC_FRACTION_BITS);
		f = acc[FIX_W+WEIGHT_SHIFT-1:WEIGHT_SHIFT];
		smooth_val[ch] = f;
		if (span_hi[ch] == span_lo[ch]) begin
			// empty range reads full scale
			lvl = longint'(full_scale);
		end else begin
			// signed quotient, truncated toward zero; an inverted range takes the same path
			lvl = (longint'(full_scale) * (longint'(span_hi[ch]) - longint'(f)))
				/ (longint'(span_hi[ch]) - longint'(span_lo[ch]));
		end
		if (lvl < 0)
			lvl = 0;
		if (lvl > LEVEL_MAX)
			lvl = LEVEL_MAX;
		if (f > span_hi[ch])
			span_hi[ch] = f;
		if (f < span_lo[ch])
			span_lo[ch] = f;
		return int'(lvl);
	endfunction

	// Work out the valve outcome of one accepted frame and advance the predictor state.
	function automatic valve_outcome_t follow_step(input sample_frame_t fr);
		valve_outcome_t o;
		int tl;
		int fl;
		int diff;
		int mag;
		int duty;
		o.mode      = MODE_EXHAUST;
		o.duty      = '0;
		o.tgt_level = '0;
		o.fol_level = '0;
		o.error     = '0;
		// unused pair: nothing moves, all-zero result
		if (int'(fr.pair) >= PFC_PAIR_COUNT)
			return o;
		fl   = track_channel(int'(fr.pair), fr.follower);
		tl   = track_channel(int'(fr.pair) + PFC_PAIR_COUNT, fr.target);
		diff = tl - fl;
		mag  = (diff < 0) ? -diff : diff;
		if (run_enable) begin
			if (mag == 0) begin
				// on target: close, polarity held as it was
				o.mode = MODE_CLOSE;
			end else begin
				duty = (int'(gain_q44) * mag) >> DUTY_SHIFT;
				push_sign[fr.pair] = (diff > 0);
				o.mode = push_sign[fr.pair] ? MODE_SUPPLY : MODE_VACUUM;
				o.duty = (duty > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : duty[LEVEL_W-1:0];
			end
		end
		o.tgt_level = tl[LEVEL_W-1:0];
		o.fol_level = fl[LEVEL_W-1:0];
		o.error     = diff[ERR_W-1:0];
		return o;
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_MAX)
			return SAMPLE_W'(SAMPLE_MAX);
		return v[SAMPLE_W-1:0];
	endfunction

	// Frame driver: present the backlog in order, honouring each frame's gap. Prediction
	// happens at the transfer edge, so register writes (done only while idle) never race it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid           <= 1'b0;
			frame_ch.pair_index      <= '0;
			frame_ch.target_sample   <= '0;
			frame_ch.follower_sample <= '0;
			gap_count = 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				valve_forecast.push_back(follow_step(frame_in_flight));
				frames_accepted++;
			end
			// the slot is free unless a frame is still waiting for ready
			if (!frame_ch.valid || frame_ch.ready) begin
				if (frame_backlog.size() == 0) begin
					frame_ch.valid <= 1'b0;
				end else if (gap_count < frame_backlog[0].gap) begin
					gap_count++;
					frame_ch.valid <= 1'b0;
				end else begin
					frame_in_flight = frame_backlog.pop_front();
					gap_count = 0;
					frame_ch.valid           <= 1'b1;
					frame_ch.pair_index      <= frame_in_flight.pair;
					frame_ch.target_sample   <= frame_in_flight.target;
					frame_ch.follower_sample <= frame_in_flight.follower;
				end
			end
		end
	end

	// Result monitor: check each transfer against the oldest forecast, then draw a stall.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		valve_outcome_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				mode_tally[int'(result_ch.valve_mode)]++;
				if (valve_forecast.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result transfer with none expected: mode %0d duty %0d",
							$time, result_ch.valve_mode, result_ch.pump_duty);
				end else begin
					want = valve_forecast.pop_front();
					if (result_ch.valve_mode !== want.mode || result_ch.pump_duty !== want.duty
						|| result_ch.target_level !== want.tgt_level
						|| result_ch.follower_level !== want.fol_level
						|| result_ch.level_error !== want.error) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mismatch: expected mode %0d duty %0d tgt %0d fol %0d err %0d",
								$time, want.mode, want.duty, want.tgt_level, want.fol_level,
								want.error);
							$display("%0t: mismatch: actual mode %0d duty %0d tgt %0d fol %0d err %0d",
								$time, result_ch.valve_mode, result_ch.pump_duty,
								result_ch.target_level, result_ch.follower_level,
								result_ch.level_error);
						end
					end
				end
				stall_left = steady ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen",
				cycle_count, results_seen, frames_issued);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Write one register through the config channel; mirror it once the transfer is seen.
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		regs_written++;
		case (idx)
			REG_ENABLE:     run_enable  = value[0];
			REG_KEEP:       keep_weight = value[COEF_W-1:0];
			REG_GAIN:       gain_q44    = value[COEF_W-1:0];
			REG_RESOLUTION: full_scale  = value[COEF_W-1:0];
			REG_RANGE_LOW: begin
				// a new start value reloads every channel's minimum
				low_start = value[SAMPLE_W-1:0];
				for (int c = 0; c < CHANNELS; c++)
					span_lo[c] = {low_start, {PFC_FRACTION_BITS{1'b0}}};
			end
			REG_RANGE_HIGH: begin
				high_start = value[SAMPLE_W-1:0];
				for (int c = 0; c < CHANNELS; c++)
					span_hi[c] = {high_start, {PFC_FRACTION_BITS{1'b0}}};
			end
			default: ;
		endcase
	endtask

	task automatic queue_frame(input int pair, input int tgt, input int fol);
		sample_frame_t fr;
		fr.pair     = pair[PAIR_W-1:0];
		fr.target   = clamp_sample(tgt);
		fr.follower = clamp_sample(fol);
		fr.gap      = steady ? 0 : $urandom_range(0, GAP_MAX);
		frame_backlog.push_back(fr);
		frames_issued++;
	endtask

	// Hold until every issued frame has come back; the block is then idle.
	task automatic wait_idle();
		while (results_seen < frames_issued)
			@(posedge clk);
	endtask

	// Random register set for one batch, leaning on the extremes.
	task automatic program_batch(input bit run);
		int pick;
		int lo;
		int hi;
		int keep;
		int gain;
		int scale;
		pick = $urandom_range(0, 4);
		keep = (pick == 0) ? 0 : (pick == 1) ? 255 : (pick == 2) ? $urandom_range(0, 64)
			: (pick == 3) ? $urandom_range(180, 255) : $urandom_range(0, 255);
		pick = $urandom_range(0, 3);
		gain = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
		pick = $urandom_range(0, 5);
		scale = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 255 : $urandom_range(1, 255);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			lo = $urandom_range(0, 511);
			hi = $urandom_range(512, SAMPLE_MAX);
		end else if (pick < 70) begin
			lo = $urandom_range(0, SAMPLE_MAX);
			hi = lo;
		end else if (pick < 85) begin
			hi = $urandom_range(0, 511);
			lo = $urandom_range(512, SAMPLE_MAX);
		end else begin
			lo = 0;
			hi = SAMPLE_MAX;
		end
		// the upper data bits are don't-care for the narrow registers: drive them at random
		program_reg(REG_ENABLE,     {9'($urandom), run});
		program_reg(REG_KEEP,       {2'($urandom), 8'(keep)});
		program_reg(REG_GAIN,       {2'($urandom), 8'(gain)});
		program_reg(REG_RESOLUTION, {2'($urandom), 8'(scale)});
		program_reg(REG_RANGE_LOW,  10'(lo));
		program_reg(REG_RANGE_HIGH, 10'(hi));
	endtask

	// Random frames: a follower chasing a drifting target in the largest share, plus matched pairs,
	// near misses, rail values, pure noise and the odd unused pair index.
	task automatic fill_batch(input int count);
		int pick;
		int pair;
		int tgt;
		int fol;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				pair = $urandom_range(PFC_PAIR_COUNT, PAIR_TOP);
			else
				pair = $urandom_range(0, PFC_PAIR_COUNT - 1);
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				tgt = chase_target[pair] + int'($urandom_range(0, 64)) - 32;
				fol = chase_follower[pair] + (tgt - chase_follower[pair]) / 4
					+ int'($urandom_range(0, 6)) - 3;
			end else if (pick < 55) begin
				tgt = $urandom_range(0, SAMPLE_MAX);
				fol = tgt;
			end else if (pick < 70) begin
				tgt = $urandom_range(0, SAMPLE_MAX);
				fol = tgt + int'($urandom_range(0, 8)) - 4;
			end else if (pick < 80) begin
				tgt = $urandom_range(0, 1) * SAMPLE_MAX;
				fol = $urandom_range(0, 1) * SAMPLE_MAX;
			end else begin
				tgt = $urandom_range(0, SAMPLE_MAX);
				fol = $urandom_range(0, SAMPLE_MAX);
			end
			chase_target[pair]   = clamp_sample(tgt);
			chase_follower[pair] = clamp_sample(fol);
			queue_frame(pair, tgt, fol);
		end
	endtask

	initial begin
		// drive every input from time zero and hold reset
		arst_n = 1'b0;
		frame_ch.valid           = 1'b0;
		frame_ch.pair_index      = '0;
		frame_ch.target_sample   = '0;
		frame_ch.follower_sample = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		steady = 1'b0;

		// predictor state after reset
		run_enable  = ENABLE_RST;
		keep_weight = KEEP_RST;
		gain_q44    = GAIN_RST;
		full_scale  = RESOLUTION_RST;
		low_start   = RANGE_LOW_RST;
		high_start  = RANGE_HIGH_RST;
		for (int c = 0; c < CHANNELS; c++) begin
			smooth_val[c] = '0;
			span_lo[c]    = {RANGE_LOW_RST, {PFC_FRACTION_BITS{1'b0}}};
			span_hi[c]    = {RANGE_HIGH_RST, {PFC_FRACTION_BITS{1'b0}}};
		end
		for (int p = 0; p < PFC_PAIR_COUNT; p++)
			push_sign[p] = 1'b0;
		for (int p = 0; p <= PAIR_TOP; p++) begin
			chase_target[p]   = 512;
			chase_follower[p] = 512;
		end
		for (int m = 0; m < 4; m++)
			mode_tally[m] = 0;

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: disabled after reset - levels still move, mode stays exhaust
		queue_frame(0, SAMPLE_MAX, 0);
		queue_frame(2, 0, SAMPLE_MAX);
		queue_frame(PAIR_TOP, SAMPLE_MAX, SAMPLE_MAX);
		wait_idle();

		// No filtering, full gain and scale: rail-to-rail errors, matched samples, a near miss and an unused pair
		program_reg(REG_ENABLE, 10'd1);
		program_reg(REG_KEEP, 10'd0);
		program_reg(REG_GAIN, 10'd255);
		program_reg(REG_RESOLUTION, 10'd255);
		queue_frame(1, SAMPLE_MAX, 0);
		queue_frame(1, 0, SAMPLE_MAX);
		queue_frame(0, 500, 500);
		queue_frame(2, 0, 0);
		queue_frame(0, 520, 500);
		queue_frame(PAIR_TOP, 0, SAMPLE_MAX);
		wait_idle();

		// Zero gain: drive direction without duty; then disable through a masked write
		program_reg(REG_GAIN, 10'd0);
		queue_frame(0, 600, 400);
		wait_idle();
		program_reg(REG_ENABLE, 10'h3FE);
		queue_frame(2, SAMPLE_MAX, 0);
		wait_idle();

		// Empty range: on the first frame both channels read full scale, so the pair closes
		program_reg(REG_ENABLE, 10'd1);
		program_reg(REG_GAIN, 10'h3FF);
		program_reg(REG_RANGE_LOW, 10'd500);
		program_reg(REG_RANGE_HIGH, 10'd500);
		queue_frame(0, 300, 700);
		queue_frame(0, 700, 300);
		wait_idle();

		// Inverted range with zero scale, then with the smallest scale
		program_reg(REG_RANGE_LOW, 10'd800);
		program_reg(REG_RANGE_HIGH, 10'd200);
		program_reg(REG_RESOLUTION, 10'h100);
		queue_frame(1, 100, 900);
		wait_idle();
		program_reg(REG_RESOLUTION, 10'd1);
		queue_frame(2, 500, 500);
		queue_frame(2, SAMPLE_MAX, 0);
		wait_idle();

		// Heaviest filtering, widest start range, and a write to an unused index
		program_reg(REG_KEEP, 10'h3FF);
		program_reg(REG_RANGE_LOW, 10'd0);
		program_reg(REG_RANGE_HIGH, 10'h3FF);
		program_reg(REG_SPARE, 10'h3FF);
		queue_frame(0, SAMPLE_MAX, 0);
		queue_frame(1, 0, SAMPLE_MAX);
		queue_frame(2, SAMPLE_MAX, SAMPLE_MAX);
		wait_idle();

		// Random batches; each starts and ends idle, so the sender waits out every result
		for (int b = 0; b < 6; b++) begin
			steady = (b == 1 || b == 4);
			program_batch(b != 2);
			fill_batch(b == 2 ? 90 : 115);
			wait_idle();
		end
		steady = 1'b0;

		// let any stray result surface before judging
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d frames (%0d accepted, %0d results) across %0d register writes",
			frames_issued, frames_accepted, results_seen, regs_written);
		$display("valve modes seen: exhaust %0d, supply %0d, vacuum %0d, close %0d; %0d mismatches",
			mode_tally[MODE_EXHAUST], mode_tally[MODE_SUPPLY], mode_tally[MODE_VACUUM],
			mode_tally[MODE_CLOSE], mismatches);
		if (mismatches == 0 && valve_forecast.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/pfc_pkg.sv
design/pfc_ifs.sv
design/pfc_regs.sv
design/pfc_ctrl.sv
design/pfc_datapath.sv
design/pneumatic_follow_controller_top.sv
verif/pneumatic_follow_controller_top_tb.sv
